>>> design/mced_pkg.sv
// Shared types and constants for the multi-car elevator dispatcher.
`default_nettype none
package mced_pkg;
  localparam int MaxCars   = 4;
  localparam int CallDepth = 16;
  localparam int RideDepth = 16;
  localparam int TopFloor  = 15;
  localparam int CarW      = $clog2(MaxCars);
  localparam int CallAw    = $clog2(CallDepth);
  localparam int RideAw    = $clog2(RideDepth);
  localparam int CallCw    = $clog2(CallDepth + 1);
  localparam int RideCw    = $clog2(RideDepth + 1);
  localparam logic [31:0] MoveCost = 32'd3;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_DOWN = 2'd1;
  localparam logic [1:0] CMD_UP   = 2'd2;

  localparam logic [2:0] REG_CAR_COUNT = 3'd0;
  localparam logic [2:0] REG_START_0   = 3'd1;
  localparam logic [2:0] REG_START_3   = 3'd4;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] call_floor;
    logic [3:0] rider_floor_down;
    logic [3:0] rider_floor_up;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  car0_floor;
    logic [3:0]  car1_floor;
    logic [3:0]  car2_floor;
    logic [3:0]  car3_floor;
    logic [31:0] travel_time;
    logic [4:0]  rides_pending;
    logic [4:0]  down_pending;
    logic [4:0]  up_pending;
    logic [1:0]  boarded;
    logic        alighted;
    logic        dropped;
    logic        any_pending;
  } out_item_t;

  function automatic logic [3:0] clamp_floor(input logic [3:0] v);
    logic [3:0] r;
    r = v;
    if (v == 4'd0) r = 4'd1;
    else if (32'(v) > TopFloor) r = 4'(TopFloor);
    return r;
  endfunction
endpackage
`default_nettype wire

>>> design/mced_list_ram.sv
// Synchronous one-read one-write RAM for call lists and the ride queue.
`default_nettype none
module mced_list_ram #(
  parameter int Depth = 16,
  parameter int Width = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> design/multi_car_elevator_dispatch_unit.sv
// Top level of the multi-car elevator dispatcher.
`default_nettype none
// Handles one item at a time. A hall call is inserted into its sorted list by
// shifting larger entries up one RAM word at a time (read, then write). A tick
// reads the head of the ride queue or of both call lists and compares car
// positions combinationally; removing a head entry shifts the rest of that
// list down one entry at a time, again by a read and then a write. The result
// is held in an output register, and the next item is accepted once that
// result is taken, at the earliest in the same cycle. No clearing pass after
// reset.
module multi_car_elevator_dispatch_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mced_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mced_pkg::out_item_t     out_data,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [3:0]         cfg_data
);
  import mced_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INSRD  = 4'd1;  // read list[pos-1]
  localparam logic [3:0] S_INSCK  = 4'd2;  // compare, shift or place
  localparam logic [3:0] S_RIDERD = 4'd3;
  localparam logic [3:0] S_RIDEEX = 4'd4;
  localparam logic [3:0] S_HEADRD = 4'd5;  // read head of current list
  localparam logic [3:0] S_HEADEX = 4'd6;
  localparam logic [3:0] S_RMRD   = 4'd7;  // read entry idx+1
  localparam logic [3:0] S_RMWR   = 4'd8;  // write entry idx
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state_r, state_nxt;
  in_item_t   item_r, item_nxt;
  logic [2:0] car_count_r, car_count_nxt;
  logic [3:0] start_r [4];
  logic [3:0] start_nxt [4];
  logic [3:0] car_r [MaxCars];
  logic [3:0] car_nxt [MaxCars];
  logic [CallCw-1:0] dcnt_r, dcnt_nxt, ucnt_r, ucnt_nxt;
  logic [RideCw-1:0] rcnt_r, rcnt_nxt;
  logic [31:0] time_r, time_nxt;
  logic [RideCw-1:0] pos_r, pos_nxt;   // wide enough for both kinds of list
  logic [1:0] list_r, list_nxt;        // 0 down, 1 up, 2 ride
  logic       uphase_r, uphase_nxt;    // tick: up list still to serve
  logic [1:0] boarded_r, boarded_nxt;
  logic       alight_r, alight_nxt, drop_r, drop_nxt;
  logic       ovalid_r, ovalid_nxt;
  out_item_t  odata_r, odata_nxt;

  logic              d_we, u_we, r_we;
  logic [CallAw-1:0] c_waddr, c_raddr;
  logic [RideAw-1:0] r_waddr, r_raddr;
  logic [3:0]        c_wdata, d_rdata, u_rdata;
  logic [3:0]        r_wfloor;
  logic [CarW-1:0]   r_wcar;
  logic [4+CarW-1:0] r_rdata;

  mced_list_ram #(.Depth(CallDepth), .Width(4)) u_down (
    .clk, .we(d_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(c_raddr), .rdata(d_rdata));
  mced_list_ram #(.Depth(CallDepth), .Width(4)) u_up (
    .clk, .we(u_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(c_raddr), .rdata(u_rdata));
  mced_list_ram #(.Depth(RideDepth), .Width(4 + CarW)) u_ride (
    .clk, .we(r_we), .waddr(r_waddr), .wdata({r_wfloor, r_wcar}), .raddr(r_raddr),
    .rdata(r_rdata));

  logic [2:0] active;
  logic [3:0] head, target;
  logic [CallCw-1:0] cnt_sel;
  logic [CallCw-1:0] in_cnt;
  logic [CarW-1:0] best;
  logic [4:0] bestd, d;
  logic [3:0] cf;
  logic       accept;

  assign in_stall  = (state_r != S_IDLE) || (ovalid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;
  assign in_cnt    = (in_data.command == CMD_DOWN) ? dcnt_r : ucnt_r;

  always_comb begin
    active = (car_count_r == 3'd0) ? 3'd1 :
             (32'(car_count_r) > MaxCars) ? 3'(MaxCars) : car_count_r;
    head    = (list_r == 2'd0) ? d_rdata : u_rdata;
    cnt_sel = (list_r == 2'd0) ? dcnt_r : ucnt_r;
    best  = '0;
    bestd = 5'd31;
    for (int i = 0; i < MaxCars; i++) begin
      d = (car_r[i] > head) ? 5'(car_r[i] - head) : 5'(head - car_r[i]);
      if (3'(i) < active && d < bestd) begin
        bestd = d;
        best  = CarW'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r; item_nxt = item_r; car_count_nxt = car_count_r;
    start_nxt = start_r; car_nxt = car_r; dcnt_nxt = dcnt_r; ucnt_nxt = ucnt_r;
    rcnt_nxt = rcnt_r; time_nxt = time_r; pos_nxt = pos_r; list_nxt = list_r;
    uphase_nxt = uphase_r; boarded_nxt = boarded_r; alight_nxt = alight_r;
    drop_nxt = drop_r; ovalid_nxt = ovalid_r; odata_nxt = odata_r;
    d_we = 1'b0; u_we = 1'b0; r_we = 1'b0;
    c_waddr = '0; c_raddr = '0; c_wdata = '0;
    r_waddr = '0; r_raddr = '0; r_wfloor = '0; r_wcar = '0;
    target = '0; cf = '0;

    if (ovalid_r && !out_stall) ovalid_nxt = 1'b0;

    if (cfg_we) begin
      if (cfg_index == REG_CAR_COUNT) car_count_nxt = cfg_data[2:0];
      else if (cfg_index >= REG_START_0 && cfg_index <= REG_START_3) begin
        start_nxt[2'(cfg_index - REG_START_0)] = clamp_floor(cfg_data);
        if (32'(cfg_index - REG_START_0) < MaxCars)
          car_nxt[CarW'(cfg_index - REG_START_0)] = clamp_floor(cfg_data);
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt = in_data;
          boarded_nxt = '0; alight_nxt = 1'b0; drop_nxt = 1'b0; uphase_nxt = 1'b0;
          if (in_data.command == CMD_DOWN || in_data.command == CMD_UP) begin
            list_nxt = (in_data.command == CMD_DOWN) ? 2'd0 : 2'd1;
            if (32'(in_cnt) >= CallDepth) begin
              drop_nxt = 1'b1;
              state_nxt = S_DONE;
            end else begin
              pos_nxt = RideCw'(in_cnt);
              if (in_data.command == CMD_DOWN) dcnt_nxt = dcnt_r + 1'b1;
              else ucnt_nxt = ucnt_r + 1'b1;
              state_nxt = S_INSRD;
            end
          end else if (in_data.command == CMD_TICK) begin
            if (rcnt_r != '0) state_nxt = S_RIDERD;
            else begin
              list_nxt = 2'd0;
              state_nxt = S_HEADRD;
            end
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_INSRD: begin
        cf = clamp_floor(item_r.call_floor);
        if (pos_r == '0) begin
          c_waddr = '0; c_wdata = cf;
          d_we = (list_r == 2'd0); u_we = (list_r == 2'd1);
          state_nxt = S_DONE;
        end else begin
          c_raddr = CallAw'(pos_r - 1'b1);
          state_nxt = S_INSCK;
        end
      end
      S_INSCK: begin
        cf = clamp_floor(item_r.call_floor);
        c_waddr = CallAw'(pos_r);
        d_we = (list_r == 2'd0); u_we = (list_r == 2'd1);
        if (head > cf) begin
          c_wdata = head;
          pos_nxt = pos_r - 1'b1;
          state_nxt = S_INSRD;
        end else begin
          c_wdata = cf;
          state_nxt = S_DONE;
        end
      end
      S_RIDERD: begin
        r_raddr = '0;
        state_nxt = S_RIDEEX;
      end
      S_RIDEEX: begin
        target = r_rdata[4+CarW-1:CarW];
        if (target < car_r[r_rdata[CarW-1:0]]) begin
          car_nxt[r_rdata[CarW-1:0]] = car_r[r_rdata[CarW-1:0]] - 1'b1;
          time_nxt = time_r + MoveCost;
        end else if (target > car_r[r_rdata[CarW-1:0]]) begin
          car_nxt[r_rdata[CarW-1:0]] = car_r[r_rdata[CarW-1:0]] + 1'b1;
          time_nxt = time_r + MoveCost;
        end
        if (car_nxt[r_rdata[CarW-1:0]] == target) begin
          alight_nxt = 1'b1;
          rcnt_nxt = rcnt_r - 1'b1;
          list_nxt = 2'd2;
          pos_nxt = '0;
          state_nxt = S_RMRD;
        end else state_nxt = S_DONE;
      end
      S_HEADRD: begin
        if (cnt_sel == '0) begin
          if (list_r == 2'd0) list_nxt = 2'd1;
          else state_nxt = S_DONE;
        end else begin
          c_raddr = '0;
          state_nxt = S_HEADEX;
        end
      end
      S_HEADEX: begin
        if (head < car_r[best]) begin
          car_nxt[best] = car_r[best] - 1'b1;
          time_nxt = time_r + MoveCost;
        end else if (head > car_r[best]) begin
          car_nxt[best] = car_r[best] + 1'b1;
          time_nxt = time_r + MoveCost;
        end
        if (car_nxt[best] == head) begin
          boarded_nxt = boarded_r + 1'b1;
          if (list_r == 2'd0) dcnt_nxt = dcnt_r - 1'b1;
          else ucnt_nxt = ucnt_r - 1'b1;
          if (32'(rcnt_r) >= RideDepth) drop_nxt = 1'b1;
          else begin
            r_we = 1'b1;
            r_waddr = RideAw'(rcnt_r);
            r_wfloor = clamp_floor((list_r == 2'd0) ? item_r.rider_floor_down
                                                    : item_r.rider_floor_up);
            r_wcar = best;
            rcnt_nxt = rcnt_r + 1'b1;
          end
          uphase_nxt = (list_r == 2'd0);
          pos_nxt = '0;
          state_nxt = S_RMRD;
        end else if (list_r == 2'd0) begin
          list_nxt = 2'd1;
          state_nxt = S_HEADRD;
        end else state_nxt = S_DONE;
      end
      S_RMRD: begin
        // shift entries down over the removed head; counts already updated
        if ((list_r == 2'd2 && pos_r >= rcnt_r) ||
            (list_r == 2'd0 && pos_r >= RideCw'(dcnt_r)) ||
            (list_r == 2'd1 && pos_r >= RideCw'(ucnt_r))) begin
          if (uphase_r) begin
            uphase_nxt = 1'b0;
            list_nxt = 2'd1;
            state_nxt = S_HEADRD;
          end else state_nxt = S_DONE;
        end else begin
          c_raddr = CallAw'(pos_r + 1'b1);
          r_raddr = RideAw'(pos_r + 1'b1);
          state_nxt = S_RMWR;
        end
      end
      S_RMWR: begin
        c_waddr = CallAw'(pos_r); c_wdata = head;
        r_waddr = RideAw'(pos_r);
        r_wfloor = r_rdata[4+CarW-1:CarW]; r_wcar = r_rdata[CarW-1:0];
        d_we = (list_r == 2'd0); u_we = (list_r == 2'd1); r_we = (list_r == 2'd2);
        pos_nxt = pos_r + 1'b1;
        state_nxt = S_RMRD;
      end
      S_DONE: begin
        if (!ovalid_r || !out_stall) begin
          ovalid_nxt = 1'b1;
          odata_nxt.car0_floor = car_r[0];
          odata_nxt.car1_floor = car_r[1];
          odata_nxt.car2_floor = car_r[2];
          odata_nxt.car3_floor = car_r[3];
          odata_nxt.travel_time = time_r;
          odata_nxt.rides_pending = 5'(rcnt_r);
          odata_nxt.down_pending = 5'(dcnt_r);
          odata_nxt.up_pending = 5'(ucnt_r);
          odata_nxt.boarded = boarded_r;
          odata_nxt.alighted = alight_r;
          odata_nxt.dropped = drop_r;
          odata_nxt.any_pending = (rcnt_r != '0) || (dcnt_r != '0) || (ucnt_r != '0);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; car_count_r <= 3'd1;
      for (int i = 0; i < 4; i++) start_r[i] <= 4'd1;
      for (int i = 0; i < MaxCars; i++) car_r[i] <= 4'd1;
      dcnt_r <= '0; ucnt_r <= '0; rcnt_r <= '0; time_r <= '0; ovalid_r <= 1'b0;
      uphase_r <= 1'b0;
    end else begin
      state_r <= state_nxt; car_count_r <= car_count_nxt; start_r <= start_nxt;
      car_r <= car_nxt; dcnt_r <= dcnt_nxt; ucnt_r <= ucnt_nxt; rcnt_r <= rcnt_nxt;
      time_r <= time_nxt; ovalid_r <= ovalid_nxt; uphase_r <= uphase_nxt;
    end
    item_r <= item_nxt; pos_r <= pos_nxt; list_r <= list_nxt;
    boarded_r <= boarded_nxt; alight_r <= alight_nxt; drop_r <= drop_nxt;
    odata_r <= odata_nxt;
  end
endmodule
`default_nettype wire

>>> design/mced_checker.sv
// Port-level checks for the elevator dispatcher, bound to the top level.
`default_nettype none
module mced_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire mced_pkg::out_item_t out_data
);
  import mced_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_any: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.any_pending ==
      ((out_data.rides_pending != 0) || (out_data.down_pending != 0) ||
       (out_data.up_pending != 0)))
    else $error("any_pending mismatch");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.alighted && out_data.boarded != 2'd0))
    else $error("alight and board in one tick");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted two items back to back");
endmodule

bind multi_car_elevator_dispatch_unit mced_checker u_mced_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data);
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the multi-car elevator dispatcher.
`timescale 1ns / 1ps
module testbench;
  import mced_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [3:0] cfg_data;

  multi_car_elevator_dispatch_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // dispatcher state as predicted
  logic [2:0] cars_cfg;
  logic [3:0] car_pos [4];
  logic [3:0] down_list [$];
  logic [3:0] up_list [$];
  logic [3:0] ride_dest [$];
  logic [1:0] ride_car [$];
  logic [31:0] travel_total;
  logic move_dropped;

  in_item_t pending_calls [$];
  out_item_t expected_status [$];
  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int cycles;
  int transfers_in;
  int transfers_out;
  int drops_seen;
  int boards_seen;
  int alights_seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [3:0] sat_floor(input logic [3:0] v);
    if (v == 4'd0) return 4'd1;
    if (int'(v) > TopFloor) return 4'(TopFloor);
    return v;
  endfunction

  function automatic int cars_in_service();
    if (cars_cfg == 3'd0) return 1;
    if (int'(cars_cfg) > MaxCars) return MaxCars;
    return int'(cars_cfg);
  endfunction

  // one floor toward target; true once there
  function automatic logic move_car(input int car, input logic [3:0] target);
    if (target < car_pos[car]) begin
      car_pos[car] = car_pos[car] - 4'd1;
      travel_total = travel_total + MoveCost;
    end else if (target > car_pos[car]) begin
      car_pos[car] = car_pos[car] + 4'd1;
      travel_total = travel_total + MoveCost;
    end
    return car_pos[car] == target;
  endfunction

  function automatic int nearest_car(input logic [3:0] target);
    int best;
    int best_dist;
    int d;
    best = 0;
    best_dist = 999999;
    for (int i = 0; i < cars_in_service(); i++) begin
      d = int'(car_pos[i]) - int'(target);
      if (d < 0) d = -d;
      if (d < best_dist) begin
        best_dist = d;
        best = i;
      end
    end
    return best;
  endfunction

  function automatic void add_ride(input logic [3:0] rider, input int car);
    if (ride_dest.size() >= RideDepth) move_dropped = 1'b1;
    else begin
      ride_dest.insert(ride_dest.size(), rider);
      ride_car.insert(ride_car.size(), 2'(car));
    end
  endfunction

  function automatic int serve_down(input logic [3:0] rider);
    int car;
    if (down_list.size() == 0) return 0;
    car = nearest_car(down_list[0]);
    if (!move_car(car, down_list[0])) return 0;
    void'(down_list.pop_front());
    add_ride(rider, car);
    return 1;
  endfunction

  function automatic int serve_up(input logic [3:0] rider);
    int car;
    if (up_list.size() == 0) return 0;
    car = nearest_car(up_list[0]);
    if (!move_car(car, up_list[0])) return 0;
    void'(up_list.pop_front());
    add_ride(rider, car);
    return 1;
  endfunction

  function automatic out_item_t dispatch_status(input in_item_t it);
    out_item_t r;
    int pos;
    int nb;
    logic [3:0] fl;
    logic left;
    fl = sat_floor(it.call_floor);
    nb = 0;
    left = 1'b0;
    move_dropped = 1'b0;
    if (it.command == CMD_DOWN) begin
      if (down_list.size() >= CallDepth) move_dropped = 1'b1;
      else begin
        pos = down_list.size();
        while (pos > 0 && down_list[pos-1] > fl) pos--;
        down_list.insert(pos, fl);
      end
    end else if (it.command == CMD_UP) begin
      if (up_list.size() >= CallDepth) move_dropped = 1'b1;
      else begin
        pos = up_list.size();
        while (pos > 0 && up_list[pos-1] > fl) pos--;
        up_list.insert(pos, fl);
      end
    end else if (it.command == CMD_TICK) begin
      if (ride_dest.size() > 0) begin
        if (move_car(int'(ride_car[0]), ride_dest[0])) begin
          void'(ride_dest.pop_front());
          void'(ride_car.pop_front());
          left = 1'b1;
        end
      end else begin
        nb += serve_down(sat_floor(it.rider_floor_down));
        nb += serve_up(sat_floor(it.rider_floor_up));
      end
    end
    r.car0_floor = car_pos[0];
    r.car1_floor = car_pos[1];
    r.car2_floor = car_pos[2];
    r.car3_floor = car_pos[3];
    r.travel_time = travel_total;
    r.rides_pending = 5'(ride_dest.size());
    r.down_pending = 5'(down_list.size());
    r.up_pending = 5'(up_list.size());
    r.boarded = 2'(nb);
    r.alighted = left;
    r.dropped = move_dropped;
    r.any_pending = (ride_dest.size() + down_list.size() + up_list.size()) != 0;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on transfer %0d: %s expected %0d got %0d",
                 transfers_out, name, want, got);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_status.insert(expected_status.size(), dispatch_status(in_data));
        transfers_in++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_calls.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_calls.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL multi_car_elevator_dispatch_unit");
      $finish;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      if (rst_n && out_valid && !out_stall) begin
        transfers_out++;
        if (expected_status.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transfer %0d", transfers_out);
        end else begin
          want = expected_status.pop_front();
          check_field("car0_floor", 32'(want.car0_floor), 32'(out_data.car0_floor));
          check_field("car1_floor", 32'(want.car1_floor), 32'(out_data.car1_floor));
          check_field("car2_floor", 32'(want.car2_floor), 32'(out_data.car2_floor));
          check_field("car3_floor", 32'(want.car3_floor), 32'(out_data.car3_floor));
          check_field("travel_time", want.travel_time, out_data.travel_time);
          check_field("rides_pending", 32'(want.rides_pending),
                      32'(out_data.rides_pending));
          check_field("down_pending", 32'(want.down_pending), 32'(out_data.down_pending));
          check_field("up_pending", 32'(want.up_pending), 32'(out_data.up_pending));
          check_field("boarded", 32'(want.boarded), 32'(out_data.boarded));
          check_field("alighted", 32'(want.alighted), 32'(out_data.alighted));
          check_field("dropped", 32'(want.dropped), 32'(out_data.dropped));
          check_field("any_pending", 32'(want.any_pending), 32'(out_data.any_pending));
          drops_seen += want.dropped;
          boards_seen += want.boarded;
          alights_seen += want.alighted;
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [3:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_CAR_COUNT) cars_cfg = val[2:0];
    else car_pos[idx - REG_START_0] = sat_floor(val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_calls.size() > 0 || in_valid || expected_status.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic void queue_item(input in_item_t it);
    pending_calls.insert(pending_calls.size(), it);
  endfunction

  function automatic in_item_t make_call(input logic [1:0] cmd, input logic [3:0] fl,
                                         input logic [3:0] rd, input logic [3:0] ru);
    in_item_t it;
    it.command = cmd;
    it.call_floor = fl;
    it.rider_floor_down = rd;
    it.rider_floor_up = ru;
    return it;
  endfunction

  function automatic in_item_t random_item(input int tick_pct);
    int r;
    logic [1:0] cmd;
    r = $urandom_range(0, 99);
    if (r < tick_pct) cmd = CMD_TICK;
    else if (r < 97) cmd = (r % 2) ? CMD_DOWN : CMD_UP;
    else cmd = CMD_NONE;
    return make_call(cmd, 4'($urandom), 4'($urandom), 4'($urandom));
  endfunction

  // per phase: car count and the four start floors
  logic [3:0] phase_cfg [6][5] = '{
    '{4'd4, 4'd15, 4'd0, 4'd8, 4'd1},
    '{4'd1, 4'd7, 4'd15, 4'd3, 4'd12},
    '{4'd0, 4'd1, 4'd1, 4'd15, 4'd15},
    '{4'd7, 4'd10, 4'd5, 4'd2, 4'd14},
    '{4'd2, 4'd15, 4'd15, 4'd15, 4'd15},
    '{4'd3, 4'd6, 4'd9, 4'd0, 4'd11}
  };

  initial begin
    int burst;
    logic [1:0] burst_cmd;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cars_cfg = 3'd1;
    for (int i = 0; i < 4; i++) car_pos[i] = 4'd1;
    travel_total = '0;
    mismatches = 0;
    cycles = 0;
    transfers_in = 0;
    transfers_out = 0;
    drops_seen = 0;
    boards_seen = 0;
    alights_seen = 0;
    send_idle_pct = 18;
    recv_idle_pct = 69;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: floor extremes, every command, full list
    queue_item(make_call(CMD_TICK, 4'd5, 4'd0, 4'd15));
    queue_item(make_call(CMD_NONE, 4'd15, 4'd15, 4'd15));
    queue_item(make_call(CMD_DOWN, 4'd0, 4'd15, 4'd0));
    queue_item(make_call(CMD_UP, 4'd15, 4'd0, 4'd15));
    for (int i = 0; i < 17; i++)
      queue_item(make_call(CMD_DOWN, 4'(15 - i), 4'd3, 4'd3));
    queue_item(make_call(CMD_TICK, 4'd0, 4'd15, 4'd15));
    queue_item(make_call(CMD_TICK, 4'd0, 4'd0, 4'd0));
    queue_item(make_call(CMD_TICK, 4'd0, 4'd15, 4'd15));
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 69;
        recv_idle_pct = 18;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(REG_CAR_COUNT, phase_cfg[ph][0]);
      for (int c = 0; c < 4; c++)
        write_reg(REG_START_0 + 3'(c), phase_cfg[ph][c+1]);
      burst = 0;
      while (burst < 250) begin
        if ($urandom_range(0, 15) == 0) begin
          // run of calls to fill a list, then ticks to work it off
          burst_cmd = $urandom_range(0, 1) ? CMD_DOWN : CMD_UP;
          for (int k = 0; k < 18; k++)
            queue_item(make_call(burst_cmd, 4'($urandom), 4'($urandom), 4'($urandom)));
          for (int k = 0; k < 20; k++)
            queue_item(random_item(90));
          burst += 38;
        end else begin
          queue_item(random_item(60));
          burst++;
        end
      end
      wait_drained();
    end

    repeat (100) @(posedge clk);
    $display("%0d transfers in, %0d out over 6 car settings; %0d boarded, %0d alighted,",
             transfers_in, transfers_out, boards_seen, alights_seen);
    $display("%0d dropped entries, %0d mismatches", drops_seen, mismatches);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("PASS multi_car_elevator_dispatch_unit");
    end else begin
      $display("FAIL multi_car_elevator_dispatch_unit");
    end
    $finish;
  end
endmodule
